// ===== src/grid_neighbor_expansion_unit_assert.svh =====
// Assertion macros for the grid neighbor expansion unit.
`ifndef GRID_NEIGHBOR_EXPANSION_UNIT_ASSERT_SVH
`define GRID_NEIGHBOR_EXPANSION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GNE_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("grid neighbor expansion: same-cycle check failed");

// Next-cycle implication.
`define GNE_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("grid neighbor expansion: next-cycle check failed");

`endif

// ===== src/gne_pkg.sv =====
package gne_pkg;

    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int ROWI_W    = ROW_W + 2;
    localparam int CELL_W    = 6;
    localparam int WIN       = 5;
    localparam int WIN_W     = $clog2(WIN);
    localparam int NBR       = 8;
    localparam int CNT_W     = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int STEP_DX [NBR] = '{0, 0, -1, 1, -1, 1, -1, 1};
    localparam int STEP_DY [NBR] = '{-1, 1, 0, 0, -1, -1, 1, 1};

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WRD  = 6'b000010,
        S_WWR  = 6'b000100,
        S_RD   = 6'b001000,
        S_WAIT = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    function automatic logic [CNT_W-1:0] popcount8(input logic [NBR-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < NBR; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== src/gne_if.sv =====
interface gne_req_if
    import gne_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              open_bit;

    modport source (output valid, output operation, output cell_x, output cell_y,
                    output open_bit, input ready);
    modport sink   (input valid, input operation, input cell_x, input cell_y,
                    input open_bit, output ready);
endinterface

interface gne_rsp_if
    import gne_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [NBR-1:0]   neighbor_mask;
    logic [CNT_W-1:0] neighbor_count;

    modport source (output valid, output neighbor_mask, output neighbor_count,
                    input ready);
    modport sink   (input valid, input neighbor_mask, input neighbor_count,
                    output ready);
endinterface

// ===== src/gne_ram.sv =====
module gne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/grid_neighbor_expansion_unit.sv =====
// Grid neighbor expansion unit: 64 x 64 one-bit occupancy grid, all open after reset.
// Channel req (valid/ready) carries operation, cell_x, cell_y, open_bit.
//   A write transaction sets one cell's open bit and yields no result; it does a
//   row read, then a row write back through the single RAM port pair.
//   A query transaction yields one rsp transaction with neighbor_mask and
//   neighbor_count. It reads five grid rows (y-2 .. y+2), one per cycle, through
//   a shared row-window extractor; rsp.valid rises after the S_RD, S_WAIT and
//   S_DONE states, and the next req can be taken from that same cycle on.
// req.ready is high only while the sequencer is idle.
// rsp is held in an output register; a new req is accepted while it waits.
//   A later query that finishes while rsp is still stalled waits in its last
//   state until rsp is taken.
// Reset (rst_n low, asynchronous) clears the sequencer, the output valid and
//   the 64 per-row valid flags; a row that was never written reads as all open,
//   so there is no clearing pass and req is ready right after reset.
`include "grid_neighbor_expansion_unit_assert.svh"

module grid_neighbor_expansion_unit
    import gne_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    gne_req_if.sink   req,
    gne_rsp_if.source rsp
);

    state_t state_reg, state_next;

    logic              op_reg;
    logic [CELL_W-1:0] x_reg;
    logic [CELL_W-1:0] y_reg;
    logic              bit_reg;
    logic [2:0]        k_reg, k_next;

    logic [GRID_ROWS-1:0] row_valid_reg;

    logic             cap_valid_reg;
    logic [WIN_W-1:0] cap_k_reg;
    logic             cap_inrange_reg;
    logic             cap_rowvalid_reg;

    logic [WIN-1:0]   win_reg [WIN];

    logic             rsp_valid_reg, rsp_valid_next;
    logic [NBR-1:0]   mask_reg;
    logic [CNT_W-1:0] count_reg;

    logic                  ram_we;
    logic [ROW_W-1:0]      ram_waddr;
    logic [GRID_COLS-1:0]  ram_wdata;
    logic [ROW_W-1:0]      ram_raddr;
    logic [GRID_COLS-1:0]  ram_rdata;

    logic signed [ROWI_W-1:0] row_s;
    logic                     row_inrange;
    logic [GRID_COLS-1:0]     wr_base;
    logic                     wr_on_grid;
    logic [GRID_COLS-1:0]     cap_row;
    logic [GRID_COLS+3:0]     cap_pad;
    logic [WIN-1:0]           cap_win;
    logic [NBR-1:0]           mask_c;
    logic                     rsp_load;
    logic                     req_fire;

    gne_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign row_s = $signed({2'b00, y_reg[ROW_W-1:0]}) - ROWI_W'(2)
                 + $signed(ROWI_W'(k_reg));
    assign row_inrange = (row_s >= 0) && (row_s < ROWI_W'(GRID_ROWS));

    assign ram_raddr = (state_reg == S_RD) ? row_s[ROW_W-1:0] : y_reg[ROW_W-1:0];

    assign wr_on_grid = (int'(x_reg) < GRID_COLS) && (int'(y_reg) < GRID_ROWS);
    assign wr_base    = row_valid_reg[y_reg[ROW_W-1:0]] ? ram_rdata : '1;
    assign ram_we     = (state_reg == S_WWR) && wr_on_grid;
    assign ram_waddr  = y_reg[ROW_W-1:0];
    assign ram_wdata  = (wr_base & ~(GRID_COLS'(1) << x_reg))
                      | (GRID_COLS'(bit_reg) << x_reg);

    always_comb
    begin
        if (!cap_inrange_reg)
        begin
            cap_row = '0;
        end
        else if (!cap_rowvalid_reg)
        begin
            cap_row = '1;
        end
        else
        begin
            cap_row = ram_rdata;
        end
    end

    assign cap_pad = {2'b00, cap_row, 2'b00};
    assign cap_win = WIN'(cap_pad >> x_reg);

    always_comb
    begin
        int r;
        int c;
        for (int i = 0; i < NBR; i++)
        begin
            r = 2 + STEP_DY[i];
            c = 2 + STEP_DX[i];
            mask_c[i] = win_reg[r][c]
                     && ((win_reg[r][c-1] && win_reg[r][c+1])
                      || (win_reg[r-1][c] && win_reg[r+1][c]));
        end
    end

    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (req_fire)
                begin
                    state_next = (req.operation == OP_QUERY) ? S_RD : S_WRD;
                end
            end
            S_WRD:
            begin
                state_next = S_WWR;
            end
            S_WWR:
            begin
                state_next = S_IDLE;
            end
            S_RD:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'(WIN - 1))
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            row_valid_reg <= '0;
            cap_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cap_valid_reg <= (state_reg == S_RD);
            rsp_valid_reg <= rsp_valid_next;
            if (ram_we)
            begin
                row_valid_reg[y_reg[ROW_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= req.operation;
            x_reg   <= req.cell_x;
            y_reg   <= req.cell_y;
            bit_reg <= req.open_bit;
        end
        cap_k_reg        <= k_reg[WIN_W-1:0];
        cap_inrange_reg  <= row_inrange;
        cap_rowvalid_reg <= row_valid_reg[row_s[ROW_W-1:0]];
        if (cap_valid_reg)
        begin
            win_reg[cap_k_reg] <= cap_win;
        end
        if (rsp_load)
        begin
            mask_reg  <= mask_c;
            count_reg <= popcount8(mask_c);
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.neighbor_mask  = mask_reg;
    assign rsp.neighbor_count = count_reg;

    `GNE_ASSERT_NOW(a_count_matches_mask, clk, rst_n, rsp.valid,
        rsp.neighbor_count == CNT_W'($countones(rsp.neighbor_mask)))
    `GNE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_fire, state_reg != S_IDLE)
    `GNE_ASSERT_NEXT(a_done_delivers, clk, rst_n,
        (state_reg == S_DONE) && !rsp_valid_reg, rsp_valid_reg)
    `GNE_ASSERT_NOW(a_query_writes_nothing, clk, rst_n,
        (state_reg == S_RD) || (state_reg == S_WAIT) || (state_reg == S_DONE),
        !ram_we && (op_reg == OP_QUERY))

endmodule
